/* rtl/dd_pkg.sv */
package dd_pkg;

  localparam int unsigned DayW      = 5;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned YearW     = 14;
  localparam int unsigned CountW    = 22;
  // Day number of a shifted year reaches about 6.1 million
  localparam int unsigned DayNumW   = 24;
  // Shifted year: year plus 400, up to 16783
  localparam int unsigned ShYearW   = 15;

  localparam logic [ShYearW-1:0] YearShift     = 15'd400;
  localparam logic [CountW-1:0]  DayCountMax   = 22'h3FFFFF;
  localparam logic [8:0]         DaysPerYear   = 9'd365;
  localparam logic [MonthW-1:0]  MonthFeb      = 4'd2;
  localparam logic [MonthW-1:0]  MonthDec      = 4'd12;
  localparam logic [DayW-1:0]    FebLeapDays   = 5'd29;

  // floor(x / 25) as (x * 1311) >> 15, exact for x below 4681
  localparam logic [10:0] Div25Mul   = 11'd1311;
  localparam int unsigned Div25Shift = 15;

  typedef struct packed {
    logic [DayW-1:0]   first_day;
    logic [MonthW-1:0] first_month;
    logic [YearW-1:0]  first_year;
    logic [DayW-1:0]   second_day;
    logic [MonthW-1:0] second_month;
    logic [YearW-1:0]  second_year;
  } dd_in_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              dates_valid;
  } dd_out_t;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [DayNumW-1:0] day_num;
    logic               ok;
  } lane_res_t;

  // Stage enables handed from the pipeline control to the lanes
  typedef struct packed {
    logic s1;
    logic s2;
  } lane_en_t;

  function automatic logic [8:0] div25(input logic [12:0] x);
    logic [23:0] prod;
    prod = 24'(x) * 24'(Div25Mul);
    return prod[Div25Shift +: 9];
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

/* rtl/dd_lane.sv */
module dd_lane (
  input  logic             clk,
  input  dd_pkg::lane_en_t en,
  input  dd_pkg::date_t    date,
  output dd_pkg::lane_res_t res
);
  import dd_pkg::*;

  logic [ShYearW-1:0] ys;
  logic [ShYearW-1:0] p;
  logic [11:0]        ya;
  logic [9:0]         yb;
  logic [8:0]         qa;
  logic [8:0]         qb;
  logic               m4;
  logic               m100;
  logic               m400;
  logic               leap;
  logic [DayW-1:0]    len;
  logic               ok;

  // stage 1 registers
  logic [DayW-1:0]    day1;
  logic [MonthW-1:0]  mon1;
  logic               ok1;
  logic               leap1;
  logic [ShYearW-1:0] ys1;
  logic [12:0]        q4;
  logic [8:0]         c100;
  logic [8:0]         c400;

  logic [DayNumW-1:0] num;

  // Leap rule from the year's quotients by 4, 100 and 400, then month length and date check
  always_comb begin
    ys   = ShYearW'(date.year) + YearShift;
    p    = ys - ShYearW'(1);
    ya   = date.year[YearW-1:2];
    yb   = date.year[YearW-1:4];
    qa   = div25(13'(ya));
    qb   = div25(13'(yb));
    m4   = (date.year[1:0] == 2'd0);
    m100 = m4 && (13'(ya) == 13'(qa) * 13'd25);
    m400 = (date.year[3:0] == 4'd0) && (13'(yb) == 13'(qb) * 13'd25);
    leap = (m4 && !m100) || m400;
    len  = (date.month == MonthFeb && leap) ? FebLeapDays : month_len(date.month);
    ok   = (date.month != '0) && (date.month <= MonthDec) && (date.day != '0) &&
           (date.day <= len);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      day1  <= date.day;
      mon1  <= date.month;
      ok1   <= ok;
      leap1 <= leap;
      ys1   <= ys;
      q4    <= p[ShYearW-1:2];
      c100  <= div25(p[ShYearW-1:2]);
      c400  <= div25(13'(p[ShYearW-1:4]));
    end
  end

  always_comb begin
    num = DayNumW'(DaysPerYear) * DayNumW'(ys1) + DayNumW'(q4) - DayNumW'(c100) +
          DayNumW'(c400) + DayNumW'(days_before(mon1)) + DayNumW'(day1) +
          DayNumW'(leap1 && (mon1 > MonthFeb));
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      res.day_num <= num;
      res.ok      <= ok1;
    end
  end

endmodule

/* rtl/dd_merge.sv */
module dd_merge (
  input  logic              clk,
  input  logic              en,
  input  dd_pkg::lane_res_t a,
  input  dd_pkg::lane_res_t b,
  output dd_pkg::dd_out_t   result
);
  import dd_pkg::*;

  logic [DayNumW-1:0] diff;
  logic [CountW-1:0]  count;

  always_comb begin
    diff = (a.day_num >= b.day_num) ? a.day_num - b.day_num : b.day_num - a.day_num;
    // saturate at the top of the count field
    count = (diff > DayNumW'(DayCountMax)) ? DayCountMax : diff[CountW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.dates_valid <= a.ok && b.ok;
      result.day_count   <= (a.ok && b.ok) ? count : '0;
    end
  end

endmodule

/* rtl/date_difference_in_days.sv */
// Absolute number of days between two proleptic Gregorian dates. Each date
// goes through its own lane, which checks it and turns it into a day number;
// a merge stage subtracts the two, saturates at the top of the 22-bit count
// and clears the count when either date is invalid. One word is taken every
// clock cycle unless a stall fills the pipeline; an accepted input is
// registered in the first lane stage, then the second lane stage, then the
// output register. A stall on the output holds every occupied stage behind
// it, and a free slot lets the input keep flowing.
module date_difference_in_days (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dd_pkg::dd_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dd_pkg::dd_out_t out_data
);
  import dd_pkg::*;

  logic      v1;
  logic      v2;
  logic      rdy1;
  logic      rdy2;
  logic      rdy3;
  lane_en_t  en;
  date_t     date_a;
  date_t     date_b;
  lane_res_t res_a;
  lane_res_t res_b;

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign en.s1    = rdy1;
  assign en.s2    = rdy2;

  assign date_a = '{day: in_data.first_day, month: in_data.first_month,
                    year: in_data.first_year};
  assign date_b = '{day: in_data.second_day, month: in_data.second_month,
                    year: in_data.second_year};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) out_valid <= v2;
    end
  end

  dd_lane u_lane_a (
    .clk  (clk),
    .en   (en),
    .date (date_a),
    .res  (res_a)
  );

  dd_lane u_lane_b (
    .clk  (clk),
    .en   (en),
    .date (date_b),
    .res  (res_b)
  );

  dd_merge u_merge (
    .clk    (clk),
    .en     (rdy3),
    .a      (res_a),
    .b      (res_b),
    .result (out_data)
  );

endmodule
